@@ src/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, constants and helper functions for the decimal scan core.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned VALUE_W      = 17;
  localparam int unsigned BCD_DIGITS   = 6;
  localparam int unsigned BCD_W        = 4 * BCD_DIGITS;
  localparam int unsigned SHIFT_W      = BCD_W + VALUE_W;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned MAX_DIGITS   = 5;
  localparam int unsigned DIGIT_COUNT_DEF = 5;

  // conversion steps per pipeline stage, one per input bit in total
  localparam int unsigned STEPS_A = 6;
  localparam int unsigned STEPS_B = 6;
  localparam int unsigned STEPS_C = VALUE_W - STEPS_A - STEPS_B;

  localparam logic [BYTE_W-1:0] SELECT_BASE    = 8'h08;
  localparam logic [BYTE_W-1:0] BLANK_SEGMENTS = 8'h00;

  // one shift-and-add-three step of the binary to bcd conversion
  function automatic logic [SHIFT_W-1:0] bcd_step(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] t;
    t = s;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (t[VALUE_W + 4*d +: 4] >= 4'd5) begin
        t[VALUE_W + 4*d +: 4] = t[VALUE_W + 4*d +: 4] + 4'd3;
      end
    end
    return {t[SHIFT_W-2:0], 1'b0};
  endfunction

  // seven-segment code of one decimal digit
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] digit);
    logic [BYTE_W-1:0] code;
    case (digit)
      4'd0:    code = 8'hAF;
      4'd1:    code = 8'hA0;
      4'd2:    code = 8'h6E;
      4'd3:    code = 8'hEA;
      4'd4:    code = 8'hE1;
      4'd5:    code = 8'hCB;
      4'd6:    code = 8'hCF;
      4'd7:    code = 8'hA2;
      4'd8:    code = 8'hEF;
      default: code = 8'hEB;
    endcase
    return code;
  endfunction

endpackage

@@ src/dss_bcd_stage.sv @@
// ----------------------------------------------------------------------------
// dss_bcd_stage
// One register stage of the pipelined binary to bcd conversion.
// ----------------------------------------------------------------------------
module dss_bcd_stage #(
  parameter int unsigned STEPS = dss_pkg::STEPS_A
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [dss_pkg::SHIFT_W-1:0] data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [dss_pkg::SHIFT_W-1:0] data_o
);

  logic                        valid_q;
  logic [dss_pkg::SHIFT_W-1:0] data_q;
  logic [dss_pkg::SHIFT_W-1:0] data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < STEPS; k++) begin
      data_d = dss_pkg::bcd_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/dss_seg_stage.sv @@
// ----------------------------------------------------------------------------
// dss_seg_stage
// Picks the shown digits, blanks leading zeros and looks up segment codes.
// ----------------------------------------------------------------------------
module dss_seg_stage #(
  parameter int unsigned DIGIT_COUNT = dss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic [dss_pkg::BCD_W-1:0]                 bcd_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] segs_o
);

  logic                                      valid_q;
  logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] segs_q;
  logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] segs_d;

  assign ready_o = !valid_q || ready_i;

  // element i is display position i, most significant first;
  // digits above the shown ones are dropped, which gives the modulo
  always_comb begin
    logic       lit;
    logic [3:0] digit;
    lit   = 1'b0;
    digit = 4'd0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digit = bcd_i[4*(DIGIT_COUNT-1-i) +: 4];
      lit   = lit || (digit != 4'd0);
      segs_d[i] = lit ? dss_pkg::seg_code(digit) : dss_pkg::BLANK_SEGMENTS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      segs_q <= segs_d;
    end
  end

  assign valid_o = valid_q;
  assign segs_o  = segs_q;

endmodule

@@ src/dss_scan_out.sv @@
// ----------------------------------------------------------------------------
// dss_scan_out
// Output register that scans out one digit result per transaction.
// ----------------------------------------------------------------------------
module dss_scan_out #(
  parameter int unsigned DIGIT_COUNT = dss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] segs_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [dss_pkg::POS_W-1:0]                   digit_position_o,
  output logic [dss_pkg::BYTE_W-1:0]                  select_pattern_o,
  output logic [dss_pkg::BYTE_W-1:0]                  segment_pattern_o,
  output logic                                        last_o
);

  localparam logic [dss_pkg::POS_W-1:0] LastPos = dss_pkg::POS_W'(DIGIT_COUNT - 1);

  logic                                        valid_q;
  logic [dss_pkg::POS_W-1:0]                   pos_q;
  logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] segs_q;
  logic                                        is_last;
  logic                                        out_fire;

  assign is_last  = (pos_q == LastPos);
  assign out_fire = valid_q && out_ready_i;
  assign ready_o  = !valid_q || (out_ready_i && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (ready_o && valid_i) begin
      valid_q <= 1'b1;
      pos_q   <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // current digit always sits in element 0
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      segs_q <= segs_i;
    end else if (out_fire) begin
      segs_q <= segs_q >> dss_pkg::BYTE_W;
    end
  end

  assign out_valid_o       = valid_q;
  assign digit_position_o  = pos_q;
  assign select_pattern_o  = dss_pkg::SELECT_BASE << pos_q;
  assign segment_pattern_o = segs_q[0];
  assign last_o            = is_last;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (pos_q <= LastPos))
    else $error("digit position beyond last digit");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !is_last) |=> (valid_q && pos_q == $past(pos_q) + 1'b1))
    else $error("digit position did not advance");

  a_new_item_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && valid_i) |=> (valid_q && pos_q == '0))
    else $error("new item does not start at first digit");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(pos_q)))
    else $error("result changed while stalled");
`endif

endmodule

@@ src/decimal_seven_segment_scan_core.sv @@
// ----------------------------------------------------------------------------
// decimal_seven_segment_scan_core
// Converts a binary value to decimal and scans out one seven-segment result
// per digit, most significant first, with leading zeros blanked.
// ----------------------------------------------------------------------------
// chan  handshake                  payload
// in    in_valid_i/in_ready_o      value_i
// out   out_valid_o/out_ready_i    digit_position_o, select_pattern_o, segment_pattern_o, last_o
//
// the first result passes the three conversion stages, the segment stage and
// the output register; the output register then gives one digit per cycle
// while out_ready_i is high, DIGIT_COUNT digits per item.
// the earlier stages keep taking new values while one is being scanned, until
// each is full. reset clears the valid bits and the digit counter. a stall at
// the output holds the output register and then, as they fill, the stages behind it.
// ----------------------------------------------------------------------------
module decimal_seven_segment_scan_core #(
  parameter int unsigned DIGIT_COUNT = dss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dss_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dss_pkg::POS_W-1:0]     digit_position_o,
  output logic [dss_pkg::BYTE_W-1:0]    select_pattern_o,
  output logic [dss_pkg::BYTE_W-1:0]    segment_pattern_o,
  output logic                          last_o
);

  logic                                        a_valid, a_ready;
  logic                                        b_valid, b_ready;
  logic                                        c_valid, c_ready;
  logic                                        s_valid, s_ready;
  logic [dss_pkg::SHIFT_W-1:0]                 a_data, b_data, c_data;
  logic [DIGIT_COUNT-1:0][dss_pkg::BYTE_W-1:0] s_segs;

  dss_bcd_stage #(.STEPS(dss_pkg::STEPS_A)) u_bcd_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  ({{dss_pkg::BCD_W{1'b0}}, value_i}),
    .valid_o (a_valid),
    .ready_i (a_ready),
    .data_o  (a_data)
  );

  dss_bcd_stage #(.STEPS(dss_pkg::STEPS_B)) u_bcd_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .data_i  (a_data),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .data_o  (b_data)
  );

  dss_bcd_stage #(.STEPS(dss_pkg::STEPS_C)) u_bcd_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .data_i  (b_data),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .data_o  (c_data)
  );

  dss_seg_stage #(.DIGIT_COUNT(DIGIT_COUNT)) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .bcd_i   (c_data[dss_pkg::SHIFT_W-1 -: dss_pkg::BCD_W]),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .segs_o  (s_segs)
  );

  dss_scan_out #(.DIGIT_COUNT(DIGIT_COUNT)) u_scan (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s_valid),
    .ready_o           (s_ready),
    .segs_i            (s_segs),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .digit_position_o  (digit_position_o),
    .select_pattern_o  (select_pattern_o),
    .segment_pattern_o (segment_pattern_o),
    .last_o            (last_o)
  );

endmodule
